// ----- hw/rtl/fvc_pkg.sv -----
// ----------------------------------------------------------------------------
// fvc_pkg: shared types, codes and helpers
// Widths, command and register codes, unit request types and saturating math.
// ----------------------------------------------------------------------------
package fvc_pkg;

  localparam int MAX_VEHICLES_DEF = 8;
  localparam int MAX_LINKS_DEF    = 16;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int DATA_W      = 32;
  localparam int CMD_W       = 3;
  localparam int VEH_W       = 3;
  localparam int LINK_W      = 4;
  localparam int CFG_INDEX_W = 4;

  localparam int MODE_ENABLE  = 0;
  localparam int MODE_NO_FORM = 1;
  localparam int MODE_NO_COLL = 2;
  localparam int MODE_NO_MIS  = 3;
  localparam int MODE_HOLD    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_POSITION  = 3'd0,
    CMD_INCIDENCE = 3'd1,
    CMD_GAIN      = 3'd2,
    CMD_DESIRED   = 3'd3,
    CMD_MISSION   = 3'd4,
    CMD_START     = 3'd5,
    CMD_TICK      = 3'd6
  } cmd_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OWN_INDEX     = 4'd0,
    REG_VEHICLE_COUNT = 4'd1,
    REG_LINK_COUNT    = 4'd2,
    REG_COLL_RADIUS   = 4'd3,
    REG_COLL_LIMIT    = 4'd4,
    REG_COLL_GAIN     = 4'd5,
    REG_SPEED_LIMIT   = 4'd6,
    REG_MODE_FLAGS    = 4'd7
  } reg_idx_t;

  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } ds_op_t;

  typedef struct packed {
    logic   start;
    ds_op_t op;
  } ds_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ds_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    else if (x < -64'sd2147483648) return 32'sh80000000;
    else return x[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] t;
    t = {a[31], a} + {b[31], b};
    if (t[32] != t[31]) return t[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return t[31:0];
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [32:0] t;
    t = {a[31], a} - {b[31], b};
    if (t[32] != t[31]) return t[32] ? 32'sh80000000 : 32'sh7fffffff;
    else return t[31:0];
  endfunction

endpackage

// ----- hw/rtl/fvc_item_if.sv -----
// ----------------------------------------------------------------------------
// fvc_item_if: input request channel
// Valid/ready channel carrying one command with its operands.
// ----------------------------------------------------------------------------
interface fvc_item_if;
  logic                              valid;
  logic                              ready;
  logic [fvc_pkg::CMD_W-1:0]         command;
  logic [fvc_pkg::VEH_W-1:0]         vehicle;
  logic [fvc_pkg::LINK_W-1:0]        link;
  logic signed [fvc_pkg::DATA_W-1:0] value_x;
  logic signed [fvc_pkg::DATA_W-1:0] value_y;
  logic signed [fvc_pkg::DATA_W-1:0] value_z;
  logic signed [fvc_pkg::DATA_W-1:0] coefficient;

  modport source(output valid, command, vehicle, link, value_x, value_y, value_z,
                 coefficient, input ready);
  modport sink(input valid, command, vehicle, link, value_x, value_y, value_z,
               coefficient, output ready);
endinterface

// ----- hw/rtl/fvc_result_if.sv -----
// ----------------------------------------------------------------------------
// fvc_result_if: velocity result channel
// Valid/ready channel carrying the velocity setpoint and limit flag.
// ----------------------------------------------------------------------------
interface fvc_result_if;
  logic                              valid;
  logic                              ready;
  logic signed [fvc_pkg::DATA_W-1:0] vel_x;
  logic signed [fvc_pkg::DATA_W-1:0] vel_y;
  logic signed [fvc_pkg::DATA_W-1:0] vel_z;
  logic                              limited;

  modport source(output valid, vel_x, vel_y, vel_z, limited, input ready);
  modport sink(input valid, vel_x, vel_y, vel_z, limited, output ready);
endinterface

// ----- hw/rtl/fvc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// fvc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface fvc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [fvc_pkg::CFG_INDEX_W-1:0]   index;
  logic [fvc_pkg::DATA_W-1:0]        data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/fvc_mul.sv -----
// ----------------------------------------------------------------------------
// fvc_mul: shared signed multiplier
// Full 32x32 signed product, registered.
// ----------------------------------------------------------------------------
module fvc_mul (
  input  logic                                clk,
  input  logic signed [fvc_pkg::DATA_W-1:0]   a,
  input  logic signed [fvc_pkg::DATA_W-1:0]   b,
  output logic signed [2*fvc_pkg::DATA_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- hw/rtl/fvc_divsqrt.sv -----
// ----------------------------------------------------------------------------
// fvc_divsqrt: shared iterative divide / square root unit
// Restoring 64/32 divide, one bit a cycle; floor square root of 64 bits,
// one 2-bit digit a cycle. Quotient must fit 32 bits.
// ----------------------------------------------------------------------------
module fvc_divsqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  fvc_pkg::ds_req_t        req,
  input  logic [63:0]             num,
  input  logic [31:0]             den,
  output fvc_pkg::ds_stat_t       stat,
  output logic [31:0]             res
);

  fvc_pkg::ds_op_t op_r;
  logic [63:0]     num_r;
  logic [31:0]     den_r;
  logic [35:0]     rem;
  logic [5:0]      cnt;
  logic            busy;
  logic            done;
  logic [35:0]     rem_sh;
  logic [35:0]     trial;
  logic            fits;
  logic [5:0]      last;

  always_comb begin
    if (op_r == fvc_pkg::OP_SQRT) begin
      rem_sh = {rem[33:0], num_r[63:62]};
      trial  = {2'b00, res, 2'b01};
      last   = 6'd31;
    end else begin
      rem_sh = {rem[34:0], num_r[63]};
      trial  = {4'b0000, den_r};
      last   = 6'd63;
    end
    fits = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        op_r  <= req.op;
        num_r <= num;
        den_r <= den;
        rem   <= '0;
        res   <= '0;
      end else if (busy) begin
        rem   <= fits ? rem_sh - trial : rem_sh;
        res   <= {res[30:0], fits};
        num_r <= (op_r == fvc_pkg::OP_SQRT) ? {num_r[61:0], 2'b00} : {num_r[62:0], 1'b0};
        cnt   <= cnt + 6'd1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divsqrt started while busy");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divsqrt done while still busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt <= last)
    else $error("divsqrt step count overran");

endmodule

// ----- hw/rtl/formation_velocity_controller.sv -----
// Sequence: loads are stored as they are accepted; a tick sums the formation term per link
//   and vehicle, a root per seen and three divides per close neighbour for collisions,
//   the norm, and three divides if the speed limit scales (64-step divide, 32-step root).
// Throughput: one request at a time; the next request is taken once the sequencer idles.
// Reset: synchronous; a pass clears all MAX_VEHICLES*MAX_LINKS entries (128 by default) of
//   the incidence memory, during which no item request is accepted.
// ----------------------------------------------------------------------------
// formation_velocity_controller: formation velocity setpoint
// Sums formation, collision and mission terms in Q16.16 and limits the norm.
// ----------------------------------------------------------------------------
module formation_velocity_controller #(
  parameter int MAX_VEHICLES = fvc_pkg::MAX_VEHICLES_DEF,
  parameter int MAX_LINKS    = fvc_pkg::MAX_LINKS_DEF,
  parameter int FRAC_BITS    = fvc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  fvc_cfg_if.sink      cfg,
  fvc_item_if.sink     item,
  fvc_result_if.source result
);

  localparam int VIW    = (MAX_VEHICLES > 1) ? $clog2(MAX_VEHICLES) : 1;
  localparam int LIW    = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int VCW    = $clog2(MAX_VEHICLES + 1);
  localparam int LCW    = $clog2(MAX_LINKS + 1);
  localparam int IDEPTH = MAX_VEHICLES * MAX_LINKS;
  localparam int IAW    = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;

  typedef enum logic [22:0] {
    S_IDLE    = 23'h000001,
    S_CLEAR   = 23'h000002,
    S_LG_RD   = 23'h000004,
    S_LG_MUL  = 23'h000008,
    S_LG_G    = 23'h000010,
    S_FS_CHK  = 23'h000020,
    S_FS_MUL  = 23'h000040,
    S_FS_ACC  = 23'h000080,
    S_FU_MUL  = 23'h000100,
    S_FU_ACC  = 23'h000200,
    S_COWN    = 23'h000400,
    S_CV      = 23'h000800,
    S_SQ_MUL  = 23'h001000,
    S_SQ_ACC  = 23'h002000,
    S_SQRT_GO = 23'h004000,
    S_SQRT_W  = 23'h008000,
    S_DV_MUL  = 23'h010000,
    S_DV_GO   = 23'h020000,
    S_DV_W    = 23'h040000,
    S_CG_MUL  = 23'h080000,
    S_CG_ACC  = 23'h100000,
    S_SUM     = 23'h200000,
    S_OUT     = 23'h400000
  } state_t;

  state_t state;

  logic [2:0]  own_index;
  logic [3:0]  vehicle_count;
  logic [4:0]  link_count;
  logic [30:0] coll_radius;
  logic [30:0] coll_limit;
  logic [30:0] coll_gain;
  logic [30:0] speed_limit;
  logic [4:0]  mode_flags;

  logic signed [31:0] pos [MAX_VEHICLES][3];
  logic signed [31:0] des [MAX_VEHICLES][3];
  logic               seen [MAX_VEHICLES];
  logic signed [31:0] gain [MAX_LINKS];
  logic signed [31:0] mis [3];
  logic signed [31:0] inc_mem [IDEPTH];
  logic signed [31:0] inc_q;

  logic               inc_we;
  logic [IAW-1:0]     inc_waddr;
  logic signed [31:0] inc_wdata;
  logic [IAW-1:0]     inc_raddr;
  logic [IAW-1:0]     clr_addr;

  logic [VCW-1:0]     v;
  logic [LCW-1:0]     l;
  logic [1:0]         k;
  logic signed [31:0] g;
  logic signed [31:0] s;
  logic signed [31:0] diff;
  logic signed [31:0] uf [3];
  logic signed [31:0] uc [3];
  logic signed [31:0] dx [3];
  logic signed [31:0] own_pos [3];
  logic signed [31:0] tau [3];
  logic [63:0]        sq;
  logic [31:0]        dlen;
  logic [30:0]        mag;
  logic               neg;
  logic               tail;
  logic               lim;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] p_sh;
  logic signed [31:0] fm;
  logic [63:0]        p_abs;

  fvc_pkg::ds_req_t   ds_req;
  fvc_pkg::ds_stat_t  ds_stat;
  logic [63:0]        ds_num;
  logic [31:0]        ds_res;
  logic signed [31:0] qs;

  logic               ovalid;
  logic signed [31:0] ovel [3];
  logic               olim;

  logic               accept;
  fvc_pkg::cmd_t      cmd;
  logic               veh_ok;
  logic               lnk_ok;
  logic [VIW-1:0]     veh_i;
  logic [LIW-1:0]     lnk_i;
  logic [VCW-1:0]     nv;
  logic [LCW-1:0]     nl;
  logic               own_ok;
  logic [VIW-1:0]     own_v;
  logic               form_on;
  logic               coll_on;
  logic [VIW-1:0]     rd_row;
  logic               v_is_own;

  function automatic logic [IAW-1:0] iaddr(input logic [VIW-1:0] vi, input logic [LIW-1:0] li);
    return IAW'(32'(vi) * MAX_LINKS + 32'(li));
  endfunction

  assign cfg.ready  = 1'b1;
  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign cmd        = fvc_pkg::cmd_t'(item.command);
  assign veh_ok     = 32'(item.vehicle) < MAX_VEHICLES;
  assign lnk_ok     = 32'(item.link) < MAX_LINKS;
  assign veh_i      = VIW'(item.vehicle);
  assign lnk_i      = LIW'(item.link);

  assign nv = (32'(vehicle_count) > MAX_VEHICLES) ? VCW'(MAX_VEHICLES) : VCW'(vehicle_count);
  assign nl = (32'(link_count) > MAX_LINKS) ? LCW'(MAX_LINKS) : LCW'(link_count);
  assign own_ok   = 32'(own_index) < MAX_VEHICLES;
  assign own_v    = VIW'(own_index);
  assign form_on  = own_ok && !mode_flags[fvc_pkg::MODE_NO_FORM] && (nl != '0);
  assign coll_on  = own_ok && !mode_flags[fvc_pkg::MODE_NO_COLL];
  assign rd_row   = (state == S_COWN) ? own_v : VIW'(v);
  assign v_is_own = (32'(v) == 32'(own_index));

  assign p_sh  = mul_p >>> FRAC_BITS;
  assign fm    = fvc_pkg::sat32(p_sh);
  assign p_abs = mul_p[63] ? -mul_p : mul_p;
  assign qs    = neg ? -$signed(ds_res) : $signed(ds_res);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      own_index     <= '0;
      vehicle_count <= 4'd1;
      link_count    <= '0;
      coll_radius   <= 31'd327680;
      coll_limit    <= 31'd196608;
      coll_gain     <= 31'd327680;
      speed_limit   <= 31'd327680;
      mode_flags    <= 5'd16;
    end else if (cfg.valid && cfg.ready) begin
      case (fvc_pkg::reg_idx_t'(cfg.index))
        fvc_pkg::REG_OWN_INDEX:     own_index     <= cfg.data[2:0];
        fvc_pkg::REG_VEHICLE_COUNT: vehicle_count <= cfg.data[3:0];
        fvc_pkg::REG_LINK_COUNT:    link_count    <= cfg.data[4:0];
        fvc_pkg::REG_COLL_RADIUS:   coll_radius   <= cfg.data[30:0];
        fvc_pkg::REG_COLL_LIMIT:    coll_limit    <= cfg.data[30:0];
        fvc_pkg::REG_COLL_GAIN:     coll_gain     <= cfg.data[30:0];
        fvc_pkg::REG_SPEED_LIMIT:   speed_limit   <= cfg.data[30:0];
        fvc_pkg::REG_MODE_FLAGS:    mode_flags    <= cfg.data[4:0];
        default: ;
      endcase
    end
  end

  // vehicle, gain and mission stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VEHICLES; i++) begin
        seen[i] <= 1'b0;
        for (int j = 0; j < 3; j++) begin
          pos[i][j] <= '0;
          des[i][j] <= '0;
        end
      end
      for (int i = 0; i < MAX_LINKS; i++) gain[i] <= 32'sd65536;
      for (int j = 0; j < 3; j++) mis[j] <= '0;
    end else if (accept) begin
      case (cmd)
        fvc_pkg::CMD_POSITION: begin
          if (veh_ok) begin
            pos[veh_i][0] <= item.value_x;
            pos[veh_i][1] <= item.value_y;
            pos[veh_i][2] <= item.value_z;
            seen[veh_i]   <= 1'b1;
          end
        end
        fvc_pkg::CMD_GAIN: begin
          if (lnk_ok) gain[lnk_i] <= item.coefficient;
        end
        fvc_pkg::CMD_DESIRED: begin
          if (veh_ok) begin
            des[veh_i][0] <= item.value_x;
            des[veh_i][1] <= item.value_y;
            des[veh_i][2] <= item.value_z;
          end
        end
        fvc_pkg::CMD_MISSION: begin
          mis[0] <= item.value_x;
          mis[1] <= item.value_y;
          mis[2] <= item.value_z;
        end
        fvc_pkg::CMD_START: begin
          if (mode_flags[fvc_pkg::MODE_HOLD]) des <= pos;
        end
        default: ;
      endcase
    end
  end

  // incidence memory
  always_comb begin
    inc_we    = 1'b0;
    inc_waddr = iaddr(veh_i, lnk_i);
    inc_wdata = item.coefficient;
    if (state == S_CLEAR) begin
      inc_we    = 1'b1;
      inc_waddr = clr_addr;
      inc_wdata = '0;
    end else if (accept && cmd == fvc_pkg::CMD_INCIDENCE && veh_ok && lnk_ok) begin
      inc_we = 1'b1;
    end
    inc_raddr = (state == S_LG_RD) ? iaddr(own_v, LIW'(l)) : iaddr(VIW'(v), LIW'(l));
  end

  always_ff @(posedge clk) begin
    if (inc_we) inc_mem[inc_waddr] <= inc_wdata;
    inc_q <= inc_mem[inc_raddr];
  end

  // shared unit operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_LG_MUL: begin
        mul_a = inc_q;
        mul_b = gain[LIW'(l)];
      end
      S_FS_MUL: begin
        mul_a = inc_q;
        mul_b = diff;
      end
      S_FU_MUL: begin
        mul_a = g;
        mul_b = s;
      end
      S_SQ_MUL: begin
        mul_a = tail ? tau[k] : dx[k];
        mul_b = tail ? tau[k] : dx[k];
      end
      S_DV_MUL: begin
        mul_a = $signed({1'b0, mag});
        mul_b = tail ? tau[k] : dx[k];
      end
      S_CG_MUL: begin
        mul_a = $signed({1'b0, coll_gain});
        mul_b = uc[k];
      end
      default: ;
    endcase
  end

  assign ds_req.start = (state == S_SQRT_GO) || (state == S_DV_GO);
  assign ds_req.op    = (state == S_SQRT_GO) ? fvc_pkg::OP_SQRT : fvc_pkg::OP_DIV;
  assign ds_num       = (state == S_SQRT_GO) ? sq : p_abs;

  fvc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  fvc_divsqrt u_divsqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (ds_req),
    .num  (ds_num),
    .den  (dlen),
    .stat (ds_stat),
    .res  (ds_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      ovalid   <= 1'b0;
      v        <= '0;
      l        <= '0;
      k        <= '0;
      tail     <= 1'b0;
      lim      <= 1'b0;
    end else begin
      if (ovalid && result.ready && state != S_OUT) ovalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IAW'(1);
          if (clr_addr == IAW'(IDEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && cmd == fvc_pkg::CMD_TICK && mode_flags[fvc_pkg::MODE_ENABLE]) begin
            for (int j = 0; j < 3; j++) begin
              uf[j] <= '0;
              uc[j] <= '0;
            end
            l    <= '0;
            k    <= '0;
            tail <= 1'b0;
            lim  <= 1'b0;
            if (form_on) state <= S_LG_RD;
            else if (coll_on) state <= S_COWN;
            else state <= S_SUM;
          end
        end
        S_LG_RD:  state <= S_LG_MUL;
        S_LG_MUL: state <= S_LG_G;
        S_LG_G: begin
          g     <= fm;
          k     <= '0;
          v     <= '0;
          s     <= '0;
          state <= S_FS_CHK;
        end
        S_FS_CHK: begin
          if (v == nv) begin
            state <= S_FU_MUL;
          end else begin
            diff  <= fvc_pkg::sub_sat(pos[rd_row][k], des[rd_row][k]);
            state <= S_FS_MUL;
          end
        end
        S_FS_MUL: state <= S_FS_ACC;
        S_FS_ACC: begin
          s     <= fvc_pkg::add_sat(s, fm);
          v     <= v + VCW'(1);
          state <= S_FS_CHK;
        end
        S_FU_MUL: state <= S_FU_ACC;
        S_FU_ACC: begin
          uf[k] <= fvc_pkg::sub_sat(uf[k], fm);
          if (k == 2'd2) begin
            k <= '0;
            if (l + LCW'(1) == nl) state <= coll_on ? S_COWN : S_SUM;
            else begin
              l     <= l + LCW'(1);
              state <= S_LG_RD;
            end
          end else begin
            k     <= k + 2'd1;
            v     <= '0;
            s     <= '0;
            state <= S_FS_CHK;
          end
        end
        S_COWN: begin
          for (int j = 0; j < 3; j++) own_pos[j] <= pos[rd_row][j];
          v     <= '0;
          state <= S_CV;
        end
        S_CV: begin
          if (v == nv) begin
            k     <= '0;
            state <= S_CG_MUL;
          end else if (v_is_own || !seen[rd_row]) begin
            v <= v + VCW'(1);
          end else begin
            for (int j = 0; j < 3; j++) dx[j] <= fvc_pkg::sub_sat(pos[rd_row][j], own_pos[j]);
            k     <= '0;
            sq    <= '0;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          sq <= sq + $unsigned(mul_p);
          if (k == 2'd2) state <= S_SQRT_GO;
          else begin
            k     <= k + 2'd1;
            state <= S_SQ_MUL;
          end
        end
        S_SQRT_GO: state <= S_SQRT_W;
        S_SQRT_W: begin
          if (ds_stat.done) begin
            dlen <= ds_res;
            k    <= '0;
            if (tail) begin
              if (ds_res > {1'b0, speed_limit}) begin
                lim   <= 1'b1;
                mag   <= speed_limit;
                state <= S_DV_MUL;
              end else begin
                state <= S_OUT;
              end
            end else if (ds_res == '0 || ds_res >= {1'b0, coll_radius}) begin
              v     <= v + VCW'(1);
              state <= S_CV;
            end else begin
              mag   <= (coll_radius - ds_res[30:0] > coll_limit) ? coll_limit
                                                                 : coll_radius - ds_res[30:0];
              state <= S_DV_MUL;
            end
          end
        end
        S_DV_MUL: state <= S_DV_GO;
        S_DV_GO: begin
          neg   <= mul_p[63];
          state <= S_DV_W;
        end
        S_DV_W: begin
          if (ds_stat.done) begin
            if (tail) tau[k] <= qs;
            else uc[k] <= fvc_pkg::sub_sat(uc[k], qs);
            if (k == 2'd2) begin
              k <= '0;
              if (tail) state <= S_OUT;
              else begin
                v     <= v + VCW'(1);
                state <= S_CV;
              end
            end else begin
              k     <= k + 2'd1;
              state <= S_DV_MUL;
            end
          end
        end
        S_CG_MUL: state <= S_CG_ACC;
        S_CG_ACC: begin
          uc[k] <= fm;
          if (k == 2'd2) begin
            k     <= '0;
            state <= S_SUM;
          end else begin
            k     <= k + 2'd1;
            state <= S_CG_MUL;
          end
        end
        S_SUM: begin
          for (int j = 0; j < 3; j++)
            tau[j] <= fvc_pkg::add_sat(fvc_pkg::add_sat(uf[j], uc[j]),
                                       mode_flags[fvc_pkg::MODE_NO_MIS] ? 32'sd0 : mis[j]);
          tail  <= 1'b1;
          k     <= '0;
          sq    <= '0;
          state <= S_SQ_MUL;
        end
        S_OUT: begin
          if (!ovalid || result.ready) begin
            ovalid <= 1'b1;
            ovel   <= tau;
            olim   <= lim;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid   = ovalid;
  assign result.vel_x   = ovel[0];
  assign result.vel_y   = ovel[1];
  assign result.vel_z   = ovel[2];
  assign result.limited = olim;

  assert property (@(posedge clk) disable iff (rst) k != 2'd3)
    else $error("component counter out of range");
  assert property (@(posedge clk) disable iff (rst) (state == S_OUT) |-> tail)
    else $error("result stage reached before the output norm");
  assert property (@(posedge clk) disable iff (rst)
      (accept && cmd == fvc_pkg::CMD_TICK && mode_flags[fvc_pkg::MODE_ENABLE])
      |=> (state != S_IDLE))
    else $error("enabled tick did not start the sequencer");
  assert property (@(posedge clk) disable iff (rst)
      ((state == S_SQRT_W) || (state == S_DV_W)) && !ds_stat.done |-> ds_stat.busy)
    else $error("waiting on an idle divide/sqrt unit");

endmodule
